>>> rtl/vrs_pkg.sv
`default_nettype none
package vrs_pkg;

  localparam int MAX_RANGES = 64;
  localparam int IDX_W      = $clog2(MAX_RANGES);
  localparam int CNT_W      = $clog2(MAX_RANGES + 1);
  localparam int BLK_W      = 16;
  localparam int BSZ_W      = 31;
  localparam int BYTE_W     = 48;
  localparam int PROD_W     = BLK_W + BSZ_W;

  localparam logic [BSZ_W-1:0] BLOCK_SIZE_RESET = BSZ_W'(65536);

  // Command codes.
  localparam logic [1:0] CMD_MARK  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_DUP  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // Configuration register indexes.
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_FILE_SIZE  = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0] first;
    logic [BLK_W-1:0] last;
  } vrs_entry_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [BYTE_W-1:0] clip_len;
  } vrs_qres_t;

endpackage
`default_nettype wire

>>> rtl/vrs_query_pipe.sv
`default_nettype none
module vrs_query_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       flush,
  input  logic                       entry_valid,
  input  vrs_pkg::vrs_entry_t        entry,
  input  logic [vrs_pkg::BSZ_W-1:0]  block_size,
  input  logic [vrs_pkg::BYTE_W-1:0] file_size,
  input  logic [vrs_pkg::BYTE_W-1:0] pos,
  input  logic [vrs_pkg::BYTE_W-1:0] len,
  output vrs_pkg::vrs_qres_t         qres
);
  import vrs_pkg::*;

  logic              va;
  logic [PROD_W-1:0] lo_a;
  logic [PROD_W-1:0] hi_a;
  logic              vb;
  logic [PROD_W-1:0] lo_b;
  logic [BYTE_W-1:0] hic_b;
  logic [BYTE_W-1:0] hi_ext;
  logic [BYTE_W-1:0] rem;
  logic              hit_c;

  assign hi_ext = {{(BYTE_W-PROD_W){1'b0}}, hi_a};
  assign rem    = hic_b - pos;
  assign hit_c  = ({{(BYTE_W-PROD_W){1'b0}}, lo_b} <= pos) && (pos < hic_b);

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      va         <= 1'b0;
      vb         <= 1'b0;
      qres.valid <= 1'b0;
    end else begin
      va         <= entry_valid;
      vb         <= va;
      qres.valid <= vb;
    end
    // Byte bounds of the entry, then the upper bound clipped to the file end.
    lo_a          <= entry.first * block_size;
    hi_a          <= entry.last * block_size;
    lo_b          <= lo_a;
    hic_b         <= (hi_ext > file_size) ? file_size : hi_ext;
    qres.hit      <= hit_c;
    qres.clip_len <= (len > rem) ? rem : len;
  end

endmodule
`default_nettype wire

>>> rtl/verified_range_set.sv
`default_nettype none
// Mark: scan, shift up, insert, merge scan, shift down, then add the bytes to the verified total.
// Query: the entry scan reads one table entry per cycle from one RAM port.
// One command is worked on at a time; a new request is
// taken while the previous result still waits in the output register.
// Reset empties the table, zeroes the verified total and sets block_size 65536, file_size 0.
module verified_range_set (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic                       cfg_index,
  input  logic [vrs_pkg::BYTE_W-1:0] cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 cmd,
  input  logic [vrs_pkg::BLK_W-1:0]  start_block,
  input  logic [vrs_pkg::BLK_W-1:0]  end_block,
  input  logic [vrs_pkg::BYTE_W-1:0] query_pos,
  input  logic [vrs_pkg::BYTE_W-1:0] query_len,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic                       is_verified,
  output logic [vrs_pkg::BYTE_W-1:0] clipped_len,
  output logic [vrs_pkg::BYTE_W-1:0] verified_bytes
);
  import vrs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN1, S_SHUP, S_INSERT, S_SCAN2, S_SHDN, S_MUL, S_ADD, S_QSCAN, S_DONE
  } state_t;

  state_t            state;
  logic [BSZ_W-1:0]  block_size;
  logic [BYTE_W-1:0] file_size;
  logic [BYTE_W-1:0] total;

  logic [BLK_W-1:0]  s_q;
  logic [BLK_W-1:0]  e_q;
  logic [BYTE_W-1:0] pos_q;
  logic [BYTE_W-1:0] len_q;

  logic [CNT_W-1:0]  n;
  logic [CNT_W-1:0]  iss;
  logic [CNT_W-1:0]  p;
  logic              p_found;
  logic [CNT_W-1:0]  ret;
  logic              rv;
  logic [IDX_W-1:0]  rtag;
  logic [IDX_W-1:0]  hit;
  logic [BLK_W-1:0]  hit_first;
  logic [PROD_W-1:0] prod;

  logic [1:0]        res_status;
  logic              res_ver;
  logic [BYTE_W-1:0] res_clen;

  vrs_entry_t        mem [MAX_RANGES];
  vrs_entry_t        rdata;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  vrs_entry_t        wr_data;

  logic [CNT_W-1:0]  iss_m1;
  logic              dup;
  logic              ext;
  logic              scan_end;
  logic [BYTE_W:0]   sum;
  vrs_qres_t         qres;

  assign in_stall = (state != S_IDLE);
  assign iss_m1   = iss - CNT_W'(1);
  assign dup      = (s_q >= rdata.first) && (s_q < rdata.last);
  assign ext      = (rdata.last == s_q);
  assign scan_end = !rv && (iss >= n);
  assign sum      = {1'b0, total} + {{(BYTE_W+1-PROD_W){1'b0}}, prod};

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = iss[IDX_W-1:0];
    wr_en   = 1'b0;
    wr_addr = rtag;
    wr_data = rdata;
    unique case (state)
      S_SCAN1: begin
        rd_en = (iss < n);
        if (rv && !dup && ext) begin
          wr_en   = 1'b1;
          wr_data = '{first: rdata.first, last: e_q};
        end
      end
      S_SHUP: begin
        // Move entries up by one, from the top down to the insert point.
        rd_en   = (iss > p);
        rd_addr = iss_m1[IDX_W-1:0];
        wr_en   = rv;
        wr_addr = rtag + IDX_W'(1);
      end
      S_INSERT: begin
        wr_en   = 1'b1;
        wr_addr = p[IDX_W-1:0];
        wr_data = '{first: s_q, last: e_q};
      end
      S_SCAN2: begin
        rd_en = (iss < n);
        if (rv && (rdata.first == e_q)) begin
          wr_en   = 1'b1;
          wr_addr = hit;
          wr_data = '{first: hit_first, last: rdata.last};
        end
      end
      S_SHDN: begin
        rd_en   = (iss < n);
        wr_en   = rv;
        wr_addr = rtag - IDX_W'(1);
      end
      S_QSCAN: begin
        rd_en = (iss < n);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_SIZE_RESET;
      file_size  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_SIZE: block_size <= cfg_data[BSZ_W-1:0];
        REG_FILE_SIZE:  file_size  <= cfg_data;
      endcase
    end
  end

  vrs_query_pipe u_query (
    .clk         (clk),
    .rst         (rst),
    .flush       (state != S_QSCAN),
    .entry_valid (rv),
    .entry       (rdata),
    .block_size  (block_size),
    .file_size   (file_size),
    .pos         (pos_q),
    .len         (len_q),
    .qres        (qres)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      total     <= '0;
      rv        <= 1'b0;
      iss       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      rv <= rd_en;
      if (rd_en) begin
        rtag <= rd_addr;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            s_q        <= start_block;
            e_q        <= end_block;
            pos_q      <= query_pos;
            len_q      <= query_len;
            res_status <= ST_DONE;
            res_ver    <= 1'b0;
            res_clen   <= '0;
            iss        <= '0;
            ret        <= '0;
            p          <= n;
            p_found    <= 1'b0;
            if (cmd == CMD_MARK) begin
              // An empty or reversed range changes nothing.
              state <= (end_block <= start_block) ? S_DONE : S_SCAN1;
            end else if (cmd == CMD_QUERY) begin
              res_clen <= query_len;
              state    <= (query_len == '0 || n == '0) ? S_DONE : S_QSCAN;
            end else if (cmd == CMD_CLEAR) begin
              n     <= '0;
              state <= S_DONE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SCAN1: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end
          if (rv && dup) begin
            res_status <= ST_DUP;
            rv         <= 1'b0;
            state      <= S_DONE;
          end else if (rv && ext) begin
            hit       <= rtag;
            hit_first <= rdata.first;
            iss       <= '0;
            rv        <= 1'b0;
            state     <= S_SCAN2;
          end else begin
            if (rv && !p_found && (rdata.first >= s_q)) begin
              p       <= CNT_W'(rtag);
              p_found <= 1'b1;
            end
            if (scan_end) begin
              if (n == CNT_W'(MAX_RANGES)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                iss   <= n;
                state <= S_SHUP;
              end
            end
          end
        end
        S_SHUP: begin
          if (rd_en) begin
            iss <= iss_m1;
          end
          if (!rv && iss <= p) begin
            state <= S_INSERT;
          end
        end
        S_INSERT: begin
          n         <= n + CNT_W'(1);
          hit       <= p[IDX_W-1:0];
          hit_first <= s_q;
          iss       <= '0;
          state     <= S_SCAN2;
        end
        S_SCAN2: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end
          if (rv && (rdata.first == e_q)) begin
            // The range that begins at end was folded into hit; now close the gap.
            iss   <= CNT_W'(rtag) + CNT_W'(1);
            rv    <= 1'b0;
            state <= S_SHDN;
          end else if (scan_end) begin
            state <= S_MUL;
          end
        end
        S_SHDN: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end
          if (scan_end) begin
            n     <= n - CNT_W'(1);
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= (e_q - s_q) * block_size;
          state <= S_ADD;
        end
        S_ADD: begin
          total <= (sum < {1'b0, file_size}) ? sum[BYTE_W-1:0] : file_size;
          state <= S_DONE;
        end
        S_QSCAN: begin
          if (rd_en) begin
            iss <= iss + CNT_W'(1);
          end
          if (qres.valid) begin
            if (qres.hit) begin
              res_ver  <= 1'b1;
              res_clen <= qres.clip_len;
              state    <= S_DONE;
            end else begin
              ret <= ret + CNT_W'(1);
              if (ret + CNT_W'(1) == n) begin
                state <= S_DONE;
              end
            end
          end
        end
        S_DONE: begin
          rv <= 1'b0;
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            status         <= res_status;
            is_verified    <= res_ver;
            clipped_len    <= res_clen;
            verified_bytes <= total;
            state          <= S_IDLE;
          end
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    n <= CNT_W'(MAX_RANGES))
    else $error("range count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted without going busy");

  a_total_cap: assert property (@(posedge clk) disable iff (rst)
    (state == S_ADD) |=> (total <= file_size))
    else $error("verified total above file size after mark");

  a_full_only_at_depth: assert property (@(posedge clk) disable iff (rst)
    (state == S_INSERT) |-> (n < CNT_W'(MAX_RANGES)))
    else $error("insert into a full table");

endmodule
`default_nettype wire
